[hw/rtl/plac_pkg.sv]
// Shared constants for the polyline length accumulator.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps

package plac_pkg;

	localparam int COORD_W  = 32;
	localparam int S_DATA_W = 2 * COORD_W;
	localparam int LEN_W    = 48;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

endpackage

[hw/rtl/polyline_length_accumulator.sv]
// Polyline length, one point at a time: the first point of a line goes from ST_IDLE
// straight to ST_FIN; every other point passes ST_DIFF, ST_SQR and ST_ROOT, paced by the
// two-bit-per-cycle squarer and the one-bit-per-cycle root unit, before ST_FIN.
// A result appears in the cycle after the last point's accumulate and waits in an output register.
// Reset (arst_n, async, active low) clears the line state, the sequencer and the output valid.
// Depends on plac_pkg, plac_sqr, plac_isqrt.
`timescale 1ns / 1ps

module polyline_length_accumulator #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [plac_pkg::S_DATA_W-1:0] s_tdata,  // x_coord[31:0], y_coord[63:32]
	input  logic                          s_tlast,  // last_point
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [plac_pkg::LEN_W-1:0]    m_tdata,  // line_length[47:0]
	output logic                          m_tuser   // saturated
);

	localparam int CW = COORD_WIDTH;
	localparam int LW = plac_pkg::LEN_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIFF = 5'b00010,
		ST_SQR  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic            last_q;
	logic            have_point_q;
	logic [LW-1:0]   run_q;
	logic            ovf_q;
	logic [CW:0]     d_q;
	logic            m_tvalid_q;
	logic [LW-1:0]   m_len_q;
	logic            m_sat_q;

	logic            accept, out_free;
	logic [CW:0]     dx_p, dx_n, dy_p, dy_n;
	logic [CW-1:0]   ax, ay;
	logic            sqr_start, sqr_done, root_start, root_done;
	logic [2*CW:0]   sq_sum;
	logic [CW:0]     root;
	logic [LW:0]     acc_sum;
	logic [LW-1:0]   new_len;
	logic            new_ovf;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign dx_p = {cur_x_q[CW-1], cur_x_q} - {prev_x_q[CW-1], prev_x_q};
	assign dx_n = {prev_x_q[CW-1], prev_x_q} - {cur_x_q[CW-1], cur_x_q};
	assign dy_p = {cur_y_q[CW-1], cur_y_q} - {prev_y_q[CW-1], prev_y_q};
	assign dy_n = {prev_y_q[CW-1], prev_y_q} - {cur_y_q[CW-1], cur_y_q};
	assign ax   = dx_p[CW] ? dx_n[CW-1:0] : dx_p[CW-1:0];
	assign ay   = dy_p[CW] ? dy_n[CW-1:0] : dy_p[CW-1:0];

	assign sqr_start  = (state_q == ST_DIFF);
	assign root_start = (state_q == ST_SQR) && sqr_done;

	plac_sqr #(.CW(CW)) u_sqr (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqr_start),
		.ax       (ax),
		.ay       (ay),
		.done     (sqr_done),
		.sum      (sq_sum)
	);

	plac_isqrt #(.CW(CW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_sum),
		.done     (root_done),
		.root     (root)
	);

	assign acc_sum = {1'b0, run_q} + {{(LW-CW){1'b0}}, d_q};
	assign new_len = acc_sum[LW] ? plac_pkg::LEN_MAX : acc_sum[LW-1:0];
	assign new_ovf = ovf_q | acc_sum[LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_point_q <= 1'b0;
			run_q        <= '0;
			ovf_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && last_q && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= have_point_q ? ST_DIFF : ST_FIN;
				end
				ST_DIFF: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					if (sqr_done)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						run_q        <= new_len;
						ovf_q        <= new_ovf;
						have_point_q <= 1'b1;
						state_q      <= ST_IDLE;
					end else if (out_free) begin
						run_q        <= '0;
						ovf_q        <= 1'b0;
						have_point_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= s_tdata[CW-1:0];
			cur_y_q <= s_tdata[plac_pkg::COORD_W +: CW];
			last_q  <= s_tlast;
			if (!have_point_q)
				d_q <= '0;
		end
		if ((state_q == ST_ROOT) && root_done)
			d_q <= root;
		if ((state_q == ST_FIN) && !last_q) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if ((state_q == ST_FIN) && last_q && out_free) begin
			m_len_q <= new_len;
			m_sat_q <= new_ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_len_q;
	assign m_tuser  = m_sat_q;

endmodule

[hw/rtl/plac_sqr.sv]
// Serial squarer: |dx|^2 + |dy|^2, two multiplier bits per cycle per lane.
// Standalone; instantiated by polyline_length_accumulator.
`timescale 1ns / 1ps

module plac_sqr #(
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] ax,
	input  logic [CW-1:0] ay,
	output logic          done,
	output logic [2*CW:0] sum
);

	localparam int MH    = (CW + 1) / 2;
	localparam int MBW   = 2 * MH;
	localparam int AW    = CW + MBW;
	localparam int CNT_W = $clog2(MH);

	logic [CW-1:0]    ax_q, ay_q;
	logic [MBW-1:0]   bx_q, by_q;
	logic [AW-1:0]    accx_q, accy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic             last_step;

	function automatic logic [AW-1:0] mac_step(input logic [AW-1:0] acc,
		input logic [CW-1:0] a, input logic [1:0] dig);
		logic [CW+1:0] pp;
		logic [CW+1:0] hi;
		pp = (dig[0] ? {2'b00, a} : '0) + (dig[1] ? {1'b0, a, 1'b0} : '0);
		hi = {2'b00, acc[AW-1:MBW]} + pp;
		return {hi, acc[MBW-1:2]};
	endfunction

	assign last_step = busy_q && (cnt_q == CNT_W'(MH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q   <= ax;
			ay_q   <= ay;
			bx_q   <= {{(MBW-CW){1'b0}}, ax};
			by_q   <= {{(MBW-CW){1'b0}}, ay};
			accx_q <= '0;
			accy_q <= '0;
		end else if (busy_q) begin
			accx_q <= mac_step(accx_q, ax_q, bx_q[1:0]);
			accy_q <= mac_step(accy_q, ay_q, by_q[1:0]);
			bx_q   <= {2'b00, bx_q[MBW-1:2]};
			by_q   <= {2'b00, by_q[MBW-1:2]};
		end
	end

	assign done = done_q;
	assign sum  = {1'b0, accx_q[2*CW-1:0]} + {1'b0, accy_q[2*CW-1:0]};

endmodule

[hw/rtl/plac_isqrt.sv]
// Restoring integer square root, one root bit per cycle.
// Standalone; instantiated by polyline_length_accumulator.
`timescale 1ns / 1ps

module plac_isqrt #(
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2*CW:0] radicand,
	output logic          done,
	output logic [CW:0]   root
);

	localparam int NR    = CW + 1;
	localparam int PW    = 2 * NR;
	localparam int CNT_W = $clog2(NR);

	logic [PW-1:0]    rad_q;
	logic [NR+1:0]    rem_q;
	logic [NR-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic             last_step;
	logic [NR+1:0]    r4, trial;
	logic             ge;

	assign last_step = busy_q && (cnt_q == CNT_W'(NR - 1));
	assign r4        = {rem_q[NR-1:0], rad_q[PW-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign ge        = (r4 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {1'b0, radicand};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (r4 - trial) : r4;
			root_q <= {root_q[NR-2:0], ge};
			rad_q  <= {rad_q[PW-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[hw/rtl/plac_checker.sv]
// Port-level checks for polyline_length_accumulator, attached by bind.
// Depends on plac_pkg.
`timescale 1ns / 1ps

module plac_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [plac_pkg::LEN_W-1:0] m_tdata,
	input logic                       m_tuser
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == plac_pkg::LEN_MAX)
		else $error("saturated length below maximum");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result raised right after an item");

endmodule

bind polyline_length_accumulator plac_checker u_plac_checker (.*);
